// File: sv/sals_pkg.sv
// shared constants for the set-associative line tag store
// operation codes and parameter defaults; no dependencies
package sals_pkg;

	localparam int DEF_SET_BITS = 6;
	localparam int DEF_WAYS = 4;
	localparam int DEF_LINE_OFFSET_BITS = 6;
	localparam int DEF_ADDR_BITS = 48;

	localparam int KIND_W = 3;
	localparam int SLOT_W = 8;
	localparam int STATE_W = 4;

	localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FILL   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SETST  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

endpackage

// File: sv/sals_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module sals_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/set_assoc_line_tag_store_core.sv
// set-associative line tag store: one ram row per set, read-modify-write
// depends on sals_pkg and sals_ram
//
//  channel | signals                                   | direction
//  in      | in_valid in_ready kind line_address new_state | to block
//  out     | out_valid out_ready hit slot found_state   | from block
//
// lookup, fill, set state, remove: ram read, then compare and write back.
// clear all: one row read and written per set, from the first set to the last.
// reset clears the per-row valid flops at once; a row never written reads as
// its reset value, so there is no clearing pass.
// one transaction in flight; a held result stalls only the write-back step.
module set_assoc_line_tag_store_core
	import sals_pkg::*;
#(
	parameter int SET_BITS = DEF_SET_BITS,
	parameter int WAYS = DEF_WAYS,
	parameter int LINE_OFFSET_BITS = DEF_LINE_OFFSET_BITS,
	parameter int ADDR_BITS = DEF_ADDR_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [KIND_W-1:0]    kind,
	input  logic [ADDR_BITS-1:0] line_address,
	input  logic [STATE_W-1:0]   new_state,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit,
	output logic [SLOT_W-1:0]    slot,
	output logic [STATE_W-1:0]   found_state
);

	localparam int NSETS = 1 << SET_BITS;
	localparam int SET_IDX_W = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int TAG_W = ADDR_BITS - LINE_OFFSET_BITS - SET_BITS;
	localparam int CNT_W = $clog2(WAYS + 1);
	localparam int HEAD_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXE  = 2'd1;
	localparam logic [1:0] ST_CRD  = 2'd2;
	localparam logic [1:0] ST_CWR  = 2'd3;

	typedef struct packed {
		logic [WAYS-1:0][TAG_W-1:0]   tag;
		logic [WAYS-1:0][STATE_W-1:0] lst;
		logic [WAYS-1:0][SLOT_W-1:0]  uslot;
		logic [WAYS-1:0][SLOT_W-1:0]  ring;
		logic [CNT_W-1:0]             ucnt;
		logic [HEAD_W-1:0]            head;
		logic [CNT_W-1:0]             fcnt;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	logic [1:0]            state_q;
	logic [KIND_W-1:0]     kind_q;
	logic [TAG_W-1:0]      tag_q;
	logic [STATE_W-1:0]    nst_q;
	logic [SET_IDX_W-1:0]  set_q;
	logic [NSETS-1:0]      row_vld_q;
	logic                  out_valid_q;
	logic                  hit_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [STATE_W-1:0]    fst_q;

	logic                  accept;
	logic                  out_free;
	logic                  done;
	logic [SET_IDX_W-1:0]  in_set;
	logic                  ram_re;
	logic [SET_IDX_W-1:0]  ram_raddr;
	logic                  ram_we;
	logic [ROW_W-1:0]      ram_rdata;
	row_t                  rst_row;
	row_t                  cur;
	row_t                  nxt;
	row_t                  clr;
	logic                  found;
	logic [HEAD_W:0]       pos;
	logic                  hit_d;
	logic [SLOT_W-1:0]     slot_d;
	logic [STATE_W-1:0]    fst_d;
	logic                  last_set;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign in_set = (SET_BITS == 0) ? '0 : SET_IDX_W'(line_address >> LINE_OFFSET_BITS);
	assign last_set = (set_q == SET_IDX_W'(NSETS - 1));
	// result register loads this cycle
	assign done = out_free && (state_q == ST_EXE || (state_q == ST_CWR && last_set));

	assign ram_re = (accept && kind != KIND_CLEAR) || state_q == ST_CRD;
	assign ram_raddr = (state_q == ST_CRD) ? set_q : in_set;
	assign ram_we = (state_q == ST_EXE && out_free) ||
	                (state_q == ST_CWR && (!last_set || out_free));

	sals_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NSETS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(set_q),
		.wdata((state_q == ST_CWR) ? clr : nxt),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// a row never written holds the reset contents of its set
	always_comb begin
		rst_row = '0;
		rst_row.fcnt = CNT_W'(WAYS);
		for (int j = 0; j < WAYS; j++) begin
			rst_row.ring[j] = SLOT_W'(int'(set_q) * WAYS + j);
		end
		cur = row_vld_q[set_q] ? row_t'(ram_rdata) : rst_row;
	end

	// first matching used entry
	always_comb begin
		found = 1'b0;
		pos = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (CNT_W'(i) < cur.ucnt && cur.tag[i] == tag_q) begin
				found = 1'b1;
				pos = (HEAD_W + 1)'(i);
			end
		end
	end

	always_comb begin
		logic [SLOT_W-1:0] fs;
		logic [SLOT_W-1:0] rs;
		logic [STATE_W-1:0] ps;
		int tail;
		nxt = cur;
		hit_d = 1'b0;
		slot_d = '0;
		fst_d = '0;
		fs = '0;
		rs = '0;
		ps = '0;
		tail = 0;
		for (int i = 0; i < WAYS; i++) begin
			if (CNT_W'(i) == CNT_W'(pos)) begin
				rs = cur.uslot[i];
				ps = cur.lst[i];
			end
			if (HEAD_W'(i) == cur.head) begin
				fs = cur.ring[i];
			end
		end
		case (kind_q)
			KIND_LOOKUP: begin
				if (found) begin
					hit_d = 1'b1;
					slot_d = rs;
					fst_d = ps;
				end
			end
			KIND_FILL: begin
				if (found) begin
					hit_d = 1'b1;
					slot_d = rs;
				end else if (cur.fcnt != '0 && cur.ucnt < CNT_W'(WAYS)) begin
					for (int i = 0; i < WAYS; i++) begin
						if (CNT_W'(i) == cur.ucnt) begin
							nxt.tag[i] = tag_q;
							nxt.lst[i] = nst_q;
							nxt.uslot[i] = fs;
						end
					end
					nxt.head = (int'(cur.head) + 1 == WAYS) ? '0 : cur.head + 1'b1;
					nxt.fcnt = cur.fcnt - 1'b1;
					nxt.ucnt = cur.ucnt + 1'b1;
					hit_d = 1'b1;
					slot_d = fs;
				end
			end
			KIND_SETST: begin
				if (found) begin
					for (int i = 0; i < WAYS; i++) begin
						if (CNT_W'(i) == CNT_W'(pos)) begin
							nxt.lst[i] = nst_q;
						end
					end
					hit_d = 1'b1;
					slot_d = rs;
				end
			end
			KIND_REMOVE: begin
				if (found) begin
					// close the gap, keeping list order
					for (int i = 0; i < WAYS - 1; i++) begin
						if (CNT_W'(i) >= CNT_W'(pos)) begin
							nxt.tag[i] = cur.tag[i+1];
							nxt.lst[i] = cur.lst[i+1];
							nxt.uslot[i] = cur.uslot[i+1];
						end
					end
					nxt.ucnt = cur.ucnt - 1'b1;
					if (cur.fcnt < CNT_W'(WAYS)) begin
						tail = int'(cur.head) + int'(cur.fcnt);
						if (tail >= WAYS) begin
							tail = tail - WAYS;
						end
						for (int j = 0; j < WAYS; j++) begin
							if (j == tail) begin
								nxt.ring[j] = rs;
							end
						end
						nxt.fcnt = cur.fcnt + 1'b1;
					end
					hit_d = 1'b1;
					slot_d = rs;
				end
			end
			default: begin
			end
		endcase
	end

	// clear: append used slots in order behind the free fifo tail
	always_comb begin
		int d;
		int room;
		int take;
		clr = cur;
		d = 0;
		room = WAYS - int'(cur.fcnt);
		take = (int'(cur.ucnt) < room) ? int'(cur.ucnt) : room;
		for (int j = 0; j < WAYS; j++) begin
			d = j + 2 * WAYS - int'(cur.head) - int'(cur.fcnt);
			if (d >= WAYS) begin
				d = d - WAYS;
			end
			if (d >= WAYS) begin
				d = d - WAYS;
			end
			if (d < take) begin
				for (int i = 0; i < WAYS; i++) begin
					if (i == d) begin
						clr.ring[j] = cur.uslot[i];
					end
				end
			end
		end
		clr.fcnt = cur.fcnt + CNT_W'(take);
		clr.ucnt = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_vld_q <= '0;
			out_valid_q <= 1'b0;
			set_q <= '0;
		end else begin
			if (out_valid_q && out_ready && !done) begin
				out_valid_q <= 1'b0;
			end
			if (ram_we) begin
				row_vld_q[set_q] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (kind == KIND_CLEAR) begin
							set_q <= '0;
							state_q <= ST_CRD;
						end else begin
							set_q <= in_set;
							state_q <= ST_EXE;
						end
					end
				end
				ST_EXE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_CRD: begin
					state_q <= ST_CWR;
				end
				ST_CWR: begin
					if (!last_set) begin
						set_q <= set_q + 1'b1;
						state_q <= ST_CRD;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			tag_q <= TAG_W'(line_address >> (LINE_OFFSET_BITS + SET_BITS));
			nst_q <= new_state;
		end
		if (state_q == ST_EXE && out_free) begin
			hit_q <= hit_d;
			slot_q <= slot_d;
			fst_q <= fst_d;
		end else if (state_q == ST_CWR && last_set && out_free) begin
			hit_q <= 1'b0;
			slot_q <= '0;
			fst_q <= '0;
		end
	end

	assign out_valid = out_valid_q;
	assign hit = hit_q;
	assign slot = slot_q;
	assign found_state = fst_q;

endmodule

// File: sv/sals_chk.sv
// port-level checker for the set-associative line tag store, bound to the top
// depends on sals_pkg and set_assoc_line_tag_store_core
module sals_chk
	import sals_pkg::*;
#(
	parameter int ADDR_BITS = DEF_ADDR_BITS
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic [KIND_W-1:0]    kind,
	input logic [ADDR_BITS-1:0] line_address,
	input logic [STATE_W-1:0]   new_state,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 hit,
	input logic [SLOT_W-1:0]    slot,
	input logic [STATE_W-1:0]   found_state
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(slot) &&
		$stable(found_state))
		else $error("result changed while stalled");

	// a waiting transaction keeps its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(kind) && $stable(line_address) &&
		$stable(new_state))
		else $error("input changed while waiting");

	// a miss carries no slot and no state
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> slot == '0 && found_state == '0)
		else $error("miss with nonzero payload");

	// one transaction at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a second transaction while busy");

	// no result appears without a transaction before it
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_ready || $past(!in_ready))
		else $error("result without work");

endmodule

bind set_assoc_line_tag_store_core sals_chk #(.ADDR_BITS(ADDR_BITS)) u_sals_chk (.*);
